FILE: sv/tcns_pkg.sv
package tcns_pkg;

    // Default build values
    localparam int MAX_WORDS_DEF = 31;
    localparam int POS_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int CFG_W   = 5;
    localparam int FIELD_W = 32;
    localparam int CHAR_W  = 8;
    localparam int KIND_W  = 2;

    localparam logic [CFG_W-1:0] NGRAM_RESET = 5'd4;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR = 2'd0,
        KIND_SPAN = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    // Requests from the sequencer to the word-start window
    typedef struct packed {
        logic issue;
        logic period;
        logic clear;
    } t_win_ctl;

endpackage

FILE: sv/tcns_window.sv
module tcns_window #(
    parameter int MAX_WORDS = tcns_pkg::MAX_WORDS_DEF,
    parameter int POS_WIDTH = tcns_pkg::POS_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  tcns_pkg::t_win_ctl         i_ctl,
    input  logic [POS_WIDTH-1:0]       i_pos,
    input  logic [tcns_pkg::CFG_W-1:0] i_ngram,
    output logic                       o_span_yes,
    output logic [POS_WIDTH-1:0]       o_start,
    output logic [POS_WIDTH-1:0]       o_len
);

    localparam int PTR_W = $clog2(MAX_WORDS + 1);
    localparam int DEPTH = 2 ** PTR_W;
    localparam int CW    = tcns_pkg::CFG_W;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_WORDS);

    // Word start offsets, a ring addressed from the head pointer
    logic [POS_WIDTH-1:0] r_mem [DEPTH];
    logic [POS_WIDTH-1:0] r_rd_data;
    logic [POS_WIDTH-1:0] r_pos;

    logic [PTR_W-1:0] r_h, n_h;
    logic [PTR_W-1:0] r_held, n_held;
    logic             r_head_zero, n_head_zero;
    logic             r_ok;
    logic             r_zero;

    logic [CW-1:0]    w_n;
    logic [CW-1:0]    w_held_c;
    logic             w_full;
    logic [PTR_W-1:0] w_base;
    logic [PTR_W-1:0] w_rd_addr;
    logic [PTR_W-1:0] w_wr_addr;

    // Clamp the word count and find where the oldest word of the span sits
    always_comb begin
        if (i_ngram == '0) begin
            w_n = CW'(1);
        end else if (i_ngram > MAX_N) begin
            w_n = MAX_N;
        end else begin
            w_n = i_ngram;
        end
        w_held_c  = CW'(r_held);
        w_full    = (w_held_c >= w_n);
        w_base    = PTR_W'(w_held_c - w_n);
        w_rd_addr = r_h + w_base;
        w_wr_addr = r_h + r_held;
    end

    // Advance the window on a boundary, restart it on a period or at end of text
    always_comb begin
        n_h         = r_h;
        n_held      = r_held;
        n_head_zero = r_head_zero;
        if (i_ctl.issue) begin
            if (w_full) begin
                n_h    = r_h + w_base + PTR_W'(1);
                n_held = PTR_W'(w_n);
            end else begin
                n_held = r_held + PTR_W'(1);
            end
            if (i_ctl.period) begin
                n_h    = w_wr_addr;
                n_held = PTR_W'(1);
            end
            n_head_zero = r_head_zero && !w_full && !i_ctl.period;
        end
        if (i_ctl.clear) begin
            n_held      = PTR_W'(1);
            n_head_zero = 1'b1;
        end
    end

    // Write the next word start, read the span start
    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_mem[w_wr_addr] <= i_pos + POS_WIDTH'(1);
            r_rd_data        <= r_mem[w_rd_addr];
            r_pos            <= i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h         <= '0;
            r_held      <= PTR_W'(1);
            r_head_zero <= 1'b1;
            r_ok        <= 1'b0;
            r_zero      <= 1'b0;
        end else begin
            r_h         <= n_h;
            r_held      <= n_held;
            r_head_zero <= n_head_zero;
            if (i_ctl.issue) begin
                r_ok   <= w_full;
                r_zero <= r_head_zero && (w_base == '0);
            end
        end
    end

    // Head entry reads as zero until the window first moves past it
    assign o_start    = r_zero ? '0 : r_rd_data;
    assign o_len      = r_pos - o_start;
    assign o_span_yes = r_ok && (o_len != '0);

endmodule

FILE: sv/text_clean_ngram_spanner_top.sv
// Text cleaner with n-gram span finder.
// Input channel (i_in_valid / o_in_ready) takes one raw text byte per item, with
// i_byte_present and i_end_of_text flags. Output channel (o_out_valid /
// i_out_ready) gives cleaned characters, n-gram spans and one end item per text;
// o_last_result marks the final result of each input item. i_cfg_we writes the
// n-gram size; write it only while no item is in flight.
// A plain letter goes straight to its character result. A word boundary (a held
// space, a period, or the end of text) is first issued to the word-start window,
// whose registered read is used in the evaluate step; that step gives the space
// or period, then a span when the window is full. The end boundary gives no
// result at evaluate, only any span and then the end item. One item can hold a
// space, a letter and an end of text, handled in that order. Results leave at most
// one per cycle; plain letters stream at one per cycle when the receiver does not
// stall, while a boundary also takes its issue and evaluate steps.
// The next item is accepted in the same cycle that the last result of the
// current item enters the output register.
// Reset clears the cleaner state, the window and the span count, and sets the
// n-gram size to 4. The end item does the same except for the n-gram size.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; no result is dropped.
module text_clean_ngram_spanner_top #(
    parameter int MAX_WORDS = tcns_pkg::MAX_WORDS_DEF,
    parameter int POS_WIDTH = tcns_pkg::POS_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [tcns_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_byte_present,
    input  logic [7:0]                 i_text_byte,
    input  logic                       i_end_of_text,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [1:0]                 o_kind,
    output logic [7:0]                 o_clean_char,
    output logic [31:0]                o_span_start,
    output logic [31:0]                o_span_length,
    output logic [31:0]                o_span_index,
    output logic [31:0]                o_total_length,
    output logic                       o_last_result
);

    localparam int PW = POS_WIDTH;
    localparam int FW = tcns_pkg::FIELD_W;
    localparam int CW = tcns_pkg::CHAR_W;

    localparam logic [CW-1:0] CH_UP_A   = 8'h41;
    localparam logic [CW-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CW-1:0] CH_LO_A   = 8'h61;
    localparam logic [CW-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CW-1:0] CH_SPACE  = 8'h20;
    localparam logic [CW-1:0] CH_PERIOD = 8'h2E;
    localparam logic [CW-1:0] CH_QUEST  = 8'h3F;
    localparam logic [CW-1:0] CH_BANG   = 8'h21;
    localparam logic [CW-1:0] CH_DASH   = 8'h2D;
    localparam logic [CW-1:0] CH_NL     = 8'h0A;
    localparam logic [CW-1:0] CH_LPAR   = 8'h28;
    localparam logic [CW-1:0] CH_RPAR   = 8'h29;
    localparam logic [CW-1:0] CASE_OFS  = 8'd32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_EVAL,
        ST_SPAN,
        ST_CHAR,
        ST_END
    } t_step;

    typedef enum logic [1:0] {
        BK_SPACE,
        BK_PERIOD,
        BK_END
    } t_bkind;

    // Pick the first step of what is left of an item's plan
    function automatic t_step f_first(input logic sp, input logic ch,
                                      input logic per, input logic en);
        t_step s;
        if (sp) begin
            s = ST_ISSUE;
        end else if (ch && per) begin
            s = ST_ISSUE;
        end else if (ch) begin
            s = ST_CHAR;
        end else if (en) begin
            s = ST_ISSUE;
        end else begin
            s = ST_IDLE;
        end
        return s;
    endfunction

    // Configuration
    logic [tcns_pkg::CFG_W-1:0] r_ngram;

    // Cleaner state, updated when an item is accepted
    logic          r_dash, n_dash;
    logic          r_after_sp, n_after_sp;
    logic          r_after_per, n_after_per;
    logic          r_sp_pend, n_sp_pend;
    logic [PW-1:0] r_clean_pos, n_clean_pos;

    // Plan of the incoming item
    logic          w_p_sp;
    logic          w_p_ch;
    logic          w_p_per;
    logic [CW-1:0] w_p_chr;
    logic [CW-1:0] w_c;
    logic          w_letter;
    logic          w_acc;

    // Sequencer and output register
    t_step            r_step, n_step;
    t_bkind           r_bk, n_bk;
    logic             r_do_sp, n_do_sp;
    logic             r_do_ch, n_do_ch;
    logic             r_ch_per, n_ch_per;
    logic             r_do_end, n_do_end;
    logic [CW-1:0]    r_ch, n_ch;
    logic [PW-1:0]    r_pos, n_pos;
    logic [FW-1:0]    r_span_cnt, n_span_cnt;

    logic             r_o_valid, n_o_valid;
    tcns_pkg::t_kind  r_o_kind, n_o_kind;
    logic [CW-1:0]    r_o_char, n_o_char;
    logic [FW-1:0]    r_o_start, n_o_start;
    logic [FW-1:0]    r_o_len, n_o_len;
    logic [FW-1:0]    r_o_index, n_o_index;
    logic [FW-1:0]    r_o_total, n_o_total;
    logic             r_o_last, n_o_last;

    // Result produced by the current step
    logic             e_valid;
    tcns_pkg::t_kind  e_kind;
    logic [CW-1:0]    e_char;
    logic [FW-1:0]    e_start;
    logic [FW-1:0]    e_len;
    logic [FW-1:0]    e_index;
    logic [FW-1:0]    e_total;
    logic             e_last;

    logic             w_out_free;
    logic             w_fire;
    logic             w_rem;

    tcns_pkg::t_win_ctl w_win;
    logic               w_span_yes;
    logic [PW-1:0]      w_start;
    logic [PW-1:0]      w_len;

    tcns_window #(
        .MAX_WORDS (MAX_WORDS),
        .POS_WIDTH (POS_WIDTH)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_win),
        .i_pos      (r_pos),
        .i_ngram    (r_ngram),
        .o_span_yes (w_span_yes),
        .o_start    (w_start),
        .o_len      (w_len)
    );

    // Hold the n-gram size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ngram <= tcns_pkg::NGRAM_RESET;
        end else if (i_cfg_we) begin
            r_ngram <= i_cfg_data;
        end
    end

    // Fold the byte and decide what it emits
    always_comb begin
        if (i_text_byte >= CH_UP_A && i_text_byte <= CH_UP_Z) begin
            w_c = i_text_byte + CASE_OFS;
        end else if (i_text_byte == CH_NL || i_text_byte == CH_LPAR ||
                     i_text_byte == CH_RPAR) begin
            w_c = CH_SPACE;
        end else if (i_text_byte == CH_QUEST || i_text_byte == CH_BANG) begin
            w_c = CH_PERIOD;
        end else begin
            w_c = i_text_byte;
        end
        w_letter = (w_c >= CH_LO_A) && (w_c <= CH_LO_Z);

        n_dash      = r_dash;
        n_after_sp  = r_after_sp;
        n_after_per = r_after_per;
        n_sp_pend   = r_sp_pend;
        w_p_sp      = 1'b0;
        w_p_ch      = 1'b0;
        w_p_per     = 1'b0;
        w_p_chr     = w_c;

        if (i_byte_present) begin
            if (w_c == CH_DASH) begin
                n_dash = 1'b1;
            end else if (r_dash && w_c == CH_SPACE) begin
                n_dash = r_dash;
            end else if (w_c == CH_PERIOD && !r_after_per) begin
                n_sp_pend   = 1'b0;
                w_p_ch      = 1'b1;
                w_p_per     = 1'b1;
                n_after_per = 1'b1;
                n_after_sp  = 1'b0;
                n_dash      = 1'b0;
            end else if (w_c == CH_SPACE && !r_after_sp && !r_after_per) begin
                n_sp_pend   = 1'b1;
                n_after_sp  = 1'b1;
                n_after_per = 1'b0;
            end else if (w_letter) begin
                w_p_sp      = r_sp_pend;
                n_sp_pend   = 1'b0;
                w_p_ch      = 1'b1;
                n_after_sp  = 1'b0;
                n_after_per = 1'b0;
                n_dash      = 1'b0;
            end
        end

        n_clean_pos = r_clean_pos + PW'(w_p_sp) + PW'(w_p_ch);

        // End of text returns the cleaner to its reset state
        if (i_end_of_text) begin
            n_dash      = 1'b0;
            n_after_sp  = 1'b1;
            n_after_per = 1'b0;
            n_sp_pend   = 1'b0;
            n_clean_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dash      <= 1'b0;
            r_after_sp  <= 1'b1;
            r_after_per <= 1'b0;
            r_sp_pend   <= 1'b0;
            r_clean_pos <= '0;
        end else if (w_acc) begin
            r_dash      <= n_dash;
            r_after_sp  <= n_after_sp;
            r_after_per <= n_after_per;
            r_sp_pend   <= n_sp_pend;
            r_clean_pos <= n_clean_pos;
        end
    end

    // Step through the plan, at most one result per cycle, waiting while the output register is held
    always_comb begin
        n_step     = r_step;
        n_bk       = r_bk;
        n_do_sp    = r_do_sp;
        n_do_ch    = r_do_ch;
        n_ch_per   = r_ch_per;
        n_do_end   = r_do_end;
        n_ch       = r_ch;
        n_pos      = r_pos;
        n_span_cnt = r_span_cnt;

        e_valid = 1'b0;
        e_kind  = tcns_pkg::KIND_CHAR;
        e_char  = '0;
        e_start = '0;
        e_len   = '0;
        e_index = '0;
        e_total = '0;
        e_last  = 1'b0;

        w_win      = '0;
        w_out_free = !r_o_valid || i_out_ready;
        w_rem      = r_do_sp || r_do_ch || r_do_end;

        case (r_step)
            ST_ISSUE: begin
                w_win.issue = 1'b1;
                n_step      = ST_EVAL;
                if (r_do_sp) begin
                    n_bk    = BK_SPACE;
                    n_do_sp = 1'b0;
                end else if (r_do_ch) begin
                    n_bk         = BK_PERIOD;
                    w_win.period = 1'b1;
                    n_do_ch      = 1'b0;
                end else begin
                    n_bk     = BK_END;
                    n_do_end = 1'b0;
                end
            end
            ST_EVAL: begin
                if (r_bk == BK_END) begin
                    n_step = w_span_yes ? ST_SPAN : ST_END;
                end else begin
                    e_valid = 1'b1;
                    e_char  = (r_bk == BK_SPACE) ? CH_SPACE : r_ch;
                    e_last  = !w_span_yes && !w_rem;
                    if (w_out_free) begin
                        n_pos  = r_pos + PW'(1);
                        n_step = w_span_yes ? ST_SPAN
                                            : f_first(r_do_sp, r_do_ch, r_ch_per, r_do_end);
                    end
                end
            end
            ST_SPAN: begin
                e_valid = 1'b1;
                e_kind  = tcns_pkg::KIND_SPAN;
                e_start = FW'(w_start);
                e_len   = FW'(w_len);
                e_index = r_span_cnt;
                e_last  = (r_bk != BK_END) && !w_rem;
                if (w_out_free) begin
                    n_span_cnt = r_span_cnt + FW'(1);
                    n_step     = (r_bk == BK_END) ? ST_END
                                 : f_first(r_do_sp, r_do_ch, r_ch_per, r_do_end);
                end
            end
            ST_CHAR: begin
                e_valid = 1'b1;
                e_char  = r_ch;
                e_last  = !r_do_end;
                if (w_out_free) begin
                    n_do_ch = 1'b0;
                    n_pos   = r_pos + PW'(1);
                    n_step  = f_first(1'b0, 1'b0, 1'b0, r_do_end);
                end
            end
            ST_END: begin
                e_valid = 1'b1;
                e_kind  = tcns_pkg::KIND_END;
                e_total = FW'(r_pos);
                e_last  = 1'b1;
                if (w_out_free) begin
                    w_win.clear = 1'b1;
                    n_span_cnt  = '0;
                    n_step      = ST_IDLE;
                end
            end
            default: begin
                n_step = ST_IDLE;
            end
        endcase

        w_fire = e_valid && w_out_free;

        // Drain the output register, then refill it from the current step
        n_o_valid = r_o_valid && !i_out_ready;
        n_o_kind  = r_o_kind;
        n_o_char  = r_o_char;
        n_o_start = r_o_start;
        n_o_len   = r_o_len;
        n_o_index = r_o_index;
        n_o_total = r_o_total;
        n_o_last  = r_o_last;
        if (w_fire) begin
            n_o_valid = 1'b1;
            n_o_kind  = e_kind;
            n_o_char  = e_char;
            n_o_start = e_start;
            n_o_len   = e_len;
            n_o_index = e_index;
            n_o_total = e_total;
            n_o_last  = e_last;
        end

        // Take the next item when idle or as the last result of this one goes out
        o_in_ready = (r_step == ST_IDLE) || (w_fire && e_last);
        w_acc      = i_in_valid && o_in_ready;
        if (w_acc) begin
            n_do_sp  = w_p_sp;
            n_do_ch  = w_p_ch;
            n_ch_per = w_p_per;
            n_do_end = i_end_of_text;
            n_ch     = w_p_chr;
            n_pos    = r_clean_pos;
            n_step   = f_first(w_p_sp, w_p_ch, w_p_per, i_end_of_text);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step     <= ST_IDLE;
            r_bk       <= BK_SPACE;
            r_do_sp    <= 1'b0;
            r_do_ch    <= 1'b0;
            r_ch_per   <= 1'b0;
            r_do_end   <= 1'b0;
            r_pos      <= '0;
            r_span_cnt <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_step     <= n_step;
            r_bk       <= n_bk;
            r_do_sp    <= n_do_sp;
            r_do_ch    <= n_do_ch;
            r_ch_per   <= n_ch_per;
            r_do_end   <= n_do_end;
            r_pos      <= n_pos;
            r_span_cnt <= n_span_cnt;
            r_o_valid  <= n_o_valid;
        end
        r_ch      <= n_ch;
        r_o_kind  <= n_o_kind;
        r_o_char  <= n_o_char;
        r_o_start <= n_o_start;
        r_o_len   <= n_o_len;
        r_o_index <= n_o_index;
        r_o_total <= n_o_total;
        r_o_last  <= n_o_last;
    end

    assign o_out_valid    = r_o_valid;
    assign o_kind         = r_o_kind;
    assign o_clean_char   = r_o_char;
    assign o_span_start   = r_o_start;
    assign o_span_length  = r_o_len;
    assign o_span_index   = r_o_index;
    assign o_total_length = r_o_total;
    assign o_last_result  = r_o_last;

endmodule

FILE: sv/tcns_checker.sv
module tcns_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_clean_char,
    input logic [31:0] o_span_index,
    input logic        o_last_result
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_kind) && $stable(o_clean_char) &&
         $stable(o_span_index) && $stable(o_last_result)))
        else $error("stalled result changed");

    // End item closes its input item
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == tcns_pkg::KIND_END) |-> o_last_result)
        else $error("end item without last mark");

    // Cleaned characters are a-z, space or period
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == tcns_pkg::KIND_CHAR) |->
        ((o_clean_char >= 8'h61 && o_clean_char <= 8'h7A) ||
         o_clean_char == 8'h20 || o_clean_char == 8'h2E))
        else $error("cleaned character out of set");

    // Span numbering restarts after an end item
    a_index_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_kind == tcns_pkg::KIND_END) |=>
        !(o_out_valid && o_kind == tcns_pkg::KIND_SPAN && o_span_index != 32'd0))
        else $error("span index not restarted after end item");

endmodule

bind text_clean_ngram_spanner_top tcns_checker u_tcns_checker (.*);

FILE: tb/sv/ngram_span_checker.sv
`timescale 1ns / 100ps

module ngram_span_checker
    import tcns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic             i_byte_present,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_text,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [1:0]       i_kind,
    input  logic [7:0]       i_clean_char,
    input  logic [31:0]      i_span_start,
    input  logic [31:0]      i_span_length,
    input  logic [31:0]      i_span_index,
    input  logic [31:0]      i_total_length,
    input  logic             i_last_result,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int WINDOW_MAX = MAX_WORDS_DEF;

    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_PERIOD   = 8'h2E;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_BANG     = 8'h21;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'd32;

    typedef struct {
        t_kind       kind;
        logic [7:0]  ch;
        logic [31:0] start;
        logic [31:0] len;
        logic [31:0] idx;
        logic [31:0] total;
        logic        last;
    } clean_result_t;

    // Results still owed by the block, oldest first
    clean_result_t cleaner_results_q[$];
    clean_result_t item_results_q[$];

    // Own copy of the cleaner and window state
    logic [CFG_W-1:0] ngram_cfg;
    logic             dash_join;
    logic             after_space;
    logic             after_period;
    logic             space_pending;
    logic [31:0]      clean_pos;
    int               words_held;
    logic [31:0]      word_start_mem [0:WINDOW_MAX];
    logic [31:0]      span_count;

    int fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (fail_count < 100)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    function automatic void push_result(t_kind k, logic [7:0] ch, logic [31:0] st,
                                        logic [31:0] ln, logic [31:0] ix, logic [31:0] tot);
        clean_result_t r;
        r.kind  = k;
        r.ch    = ch;
        r.start = st;
        r.len   = ln;
        r.idx   = ix;
        r.total = tot;
        r.last  = 1'b0;
        item_results_q.push_back(r);
    endfunction

    function automatic void clear_text();
        dash_join     = 1'b0;
        after_space   = 1'b1;
        after_period  = 1'b0;
        space_pending = 1'b0;
        clean_pos     = '0;
        words_held    = 1;
        span_count    = '0;
        for (int i = 0; i <= WINDOW_MAX; i++)
            word_start_mem[i] = '0;
    endfunction

    // Close a word at cleaned offset pos; emit a span once the window is full
    function automatic void close_word(logic [31:0] pos, bit is_period);
        int          n;
        int          base;
        logic [31:0] start;
        logic [31:0] len;
        n = (ngram_cfg == 0) ? 1 : int'(ngram_cfg);
        if (n > WINDOW_MAX) n = WINDOW_MAX;
        if (words_held > WINDOW_MAX) words_held = WINDOW_MAX;
        word_start_mem[words_held] = pos + 32'd1;
        if (words_held >= n) begin
            base  = words_held - n;
            start = word_start_mem[base];
            len   = pos - start;
            if (len != 0) begin
                push_result(KIND_SPAN, 8'd0, start, len, span_count, 32'd0);
                span_count = span_count + 32'd1;
            end
            for (int i = 0; i < n; i++)
                word_start_mem[i] = word_start_mem[base + 1 + i];
            words_held = n;
        end else begin
            words_held++;
        end
        // A period restarts the window just past itself
        if (is_period) begin
            words_held        = 1;
            word_start_mem[0] = pos + 32'd1;
        end
    endfunction

    function automatic void emit_clean(logic [7:0] ch);
        logic [31:0] pos;
        pos = clean_pos;
        push_result(KIND_CHAR, ch, 32'd0, 32'd0, 32'd0, 32'd0);
        clean_pos = clean_pos + 32'd1;
        if (ch == CH_SPACE) close_word(pos, 1'b0);
        else if (ch == CH_PERIOD) close_word(pos, 1'b1);
    endfunction

    function automatic void clean_byte(logic [7:0] raw);
        logic [7:0] c;
        c = raw;
        // Fold case and map separators
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) c = c + CASE_OFFSET;
        else if (c == CH_NEWLINE || c == CH_LPAREN || c == CH_RPAREN) c = CH_SPACE;
        else if (c == CH_QUESTION || c == CH_BANG) c = CH_PERIOD;

        if (c == CH_DASH) begin
            dash_join = 1'b1;
        end else if (dash_join && c == CH_SPACE) begin
            // spaces after a dash are swallowed
        end else if (c == CH_PERIOD && !after_period) begin
            space_pending = 1'b0;
            emit_clean(CH_PERIOD);
            after_period  = 1'b1;
            after_space   = 1'b0;
            dash_join     = 1'b0;
        end else if (c == CH_SPACE && !after_space && !after_period) begin
            space_pending = 1'b1;
            after_space   = 1'b1;
            after_period  = 1'b0;
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            if (space_pending) begin
                space_pending = 1'b0;
                emit_clean(CH_SPACE);
            end
            emit_clean(c);
            after_space  = 1'b0;
            after_period = 1'b0;
            dash_join    = 1'b0;
        end
    endfunction

    // Work out all results of one accepted item and queue them
    function automatic void predict_item(logic present, logic [7:0] text_char, logic eot);
        logic [31:0] total;
        item_results_q.delete();
        if (present) clean_byte(text_char);
        if (eot) begin
            total = clean_pos;
            close_word(total, 1'b0);
            push_result(KIND_END, 8'd0, 32'd0, 32'd0, 32'd0, total);
            clear_text();
        end
        if (item_results_q.size() > 0) item_results_q[item_results_q.size() - 1].last = 1'b1;
        foreach (item_results_q[i]) cleaner_results_q.push_back(item_results_q[i]);
    endfunction

    task automatic compare_result();
        clean_result_t want;
        if (cleaner_results_q.size() == 0) begin
            report("result with nothing expected, kind", 32'(i_kind), 32'd0);
        end else begin
            want = cleaner_results_q.pop_front();
            if (i_kind !== want.kind) report("kind", 32'(i_kind), 32'(want.kind));
            if (i_clean_char !== want.ch) report("clean_char", 32'(i_clean_char), 32'(want.ch));
            if (i_span_start !== want.start) report("span_start", i_span_start, want.start);
            if (i_span_length !== want.len) report("span_length", i_span_length, want.len);
            if (i_span_index !== want.idx) report("span_index", i_span_index, want.idx);
            if (i_total_length !== want.total)
                report("total_length", i_total_length, want.total);
            if (i_last_result !== want.last)
                report("last_result", 32'(i_last_result), 32'(want.last));
        end
    endtask

    // Track config writes, predict accepted items, check accepted results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ngram_cfg = NGRAM_RESET;
            clear_text();
            cleaner_results_q.delete();
        end else begin
            if (i_cfg_we) ngram_cfg = i_cfg_data;
            if (i_in_valid && i_in_ready)
                predict_item(i_byte_present, i_text_byte, i_end_of_text);
            if (i_out_valid && i_out_ready) compare_result();
        end
        o_pending <= cleaner_results_q.size();
    end

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import tcns_pkg::*;

    localparam int  CYCLE_LIMIT  = 600000;
    localparam int  DRAIN_CYCLES = 24;
    localparam int  MAX_GAP      = 13;
    localparam int  PHASE_ITEMS  = 58;

    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [CFG_W-1:0] i_cfg_data     = '0;
    logic             i_in_valid     = 1'b0;
    logic             i_byte_present = 1'b0;
    logic [7:0]       i_text_byte    = 8'd0;
    logic             i_end_of_text  = 1'b0;
    logic             i_out_ready    = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [1:0]       o_kind;
    logic [7:0]       o_clean_char;
    logic [31:0]      o_span_start;
    logic [31:0]      o_span_length;
    logic [31:0]      o_span_index;
    logic [31:0]      o_total_length;
    logic             o_last_result;

    int  fail_count;
    int  pending;
    int  cycle_count = 0;
    int  stall_left  = 0;
    int  recv_gap    = 0;
    bit  send_quiet  = 1'b0;
    bit  recv_quiet  = 1'b0;

    text_clean_ngram_spanner_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_byte_present (i_byte_present),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_kind         (o_kind),
        .o_clean_char   (o_clean_char),
        .o_span_start   (o_span_start),
        .o_span_length  (o_span_length),
        .o_span_index   (o_span_index),
        .o_total_length (o_total_length),
        .o_last_result  (o_last_result)
    );

    ngram_span_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_byte_present (i_byte_present),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_kind         (o_kind),
        .i_clean_char   (o_clean_char),
        .i_span_start   (o_span_start),
        .i_span_length  (o_span_length),
        .i_span_index   (o_span_index),
        .i_total_length (o_total_length),
        .i_last_result  (o_last_result),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always #2 i_clk = ~i_clk;

    // Give up on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    // Stall the result channel for a random number of cycles after each result taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (o_out_valid && i_out_ready) begin
            if ($urandom_range(0, 23) == 0) recv_quiet = !recv_quiet;
            recv_gap     = draw_gap(recv_quiet);
            stall_left  <= recv_gap;
            i_out_ready <= (recv_gap == 0) ? 1'b1 : 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Hold one item on the input channel until it is taken
    task automatic send_item(input logic present, input logic [7:0] text_char,
                             input logic eot);
        int gap;
        if ($urandom_range(0, 19) == 0) send_quiet = !send_quiet;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_byte_present <= present;
        i_text_byte    <= text_char;
        i_end_of_text  <= eot;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_ngram_size(input logic [CFG_W-1:0] size);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Mostly word-like text with separators and punctuation, some noise bytes
    task automatic send_random_text(input int item_goal);
        int         counted;
        int         pick;
        logic       present;
        logic       eot;
        logic [7:0] text_char;
        counted = 0;
        while (counted < item_goal) begin
            pick    = $urandom_range(0, 99);
            present = 1'b1;
            eot     = ($urandom_range(0, 39) == 0);
            if (pick < 50) begin
                text_char = $urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                                 : 8'($urandom_range(97, 122));
            end else if (pick < 62) begin
                text_char = " ";
            end else if (pick < 66) begin
                case ($urandom_range(0, 2))
                    0:       text_char = 8'h0A;
                    1:       text_char = "(";
                    default: text_char = ")";
                endcase
            end else if (pick < 72) begin
                case ($urandom_range(0, 2))
                    0:       text_char = ".";
                    1:       text_char = "?";
                    default: text_char = "!";
                endcase
            end else if (pick < 77) begin
                text_char = "-";
            end else if (pick < 89) begin
                text_char = 8'($urandom_range(0, 255));
            end else begin
                present   = 1'b0;
                text_char = 8'($urandom);
            end
            send_item(present, text_char, eot);
            counted++;
        end
    endtask

    initial begin
        int phase_sizes [6];

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed text with one word per span
        write_ngram_size(5'd1);
        send_item(1'b1, ".", 1'b0);     // period at start of text
        send_item(1'b1, "!", 1'b0);     // repeated period
        send_item(1'b1, "A", 1'b0);
        send_item(1'b1, "Z", 1'b0);
        send_item(1'b1, " ", 1'b0);
        send_item(1'b1, 8'h0A, 1'b0);
        send_item(1'b1, "a", 1'b0);
        send_item(1'b1, "-", 1'b0);     // dash join, then swallowed space
        send_item(1'b1, " ", 1'b0);
        send_item(1'b1, "z", 1'b0);
        send_item(1'b1, "(", 1'b0);
        send_item(1'b1, "?", 1'b0);     // space before period dropped
        send_item(1'b1, ")", 1'b0);
        send_item(1'b1, "q", 1'b0);
        send_item(1'b1, 8'h00, 1'b0);
        send_item(1'b1, 8'hFF, 1'b0);
        send_item(1'b0, 8'h5A, 1'b0);   // empty item
        send_item(1'b1, " ", 1'b0);
        send_item(1'b0, 8'h00, 1'b1);   // trailing space dropped at end
        send_item(1'b1, ".", 1'b1);     // zero-length span at end
        send_item(1'b0, 8'hA5, 1'b1);   // end of an empty text
        send_item(1'b1, "x", 1'b1);
        i_in_valid <= 1'b0;
        wait_drained();

        // Random phases; the drop from 31 to 0 cuts the window mid-text
        phase_sizes = '{2, 31, 0, 3, 4, 1};
        phase_sizes[5] = $urandom_range(1, 30);
        foreach (phase_sizes[p]) begin
            write_ngram_size(CFG_W'(phase_sizes[p]));
            send_random_text(PHASE_ITEMS);
            i_in_valid <= 1'b0;
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: text_clean_ngram_spanner_top.f
sv/tcns_pkg.sv
sv/tcns_window.sv
sv/text_clean_ngram_spanner_top.sv
sv/tcns_checker.sv
tb/sv/ngram_span_checker.sv
tb/sv/tb_top.sv
